### hw/rtl/dtd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtd_pkg
// Shared types and constants for the decimal text to double converter.
// ----------------------------------------------------------------------------
package dtd_pkg;

    // one parsed number handed from the scanner to the arithmetic unit
    typedef struct packed {
        logic        neg;
        logic [59:0] mant;
        logic [13:0] idc;
        logic [4:0]  kdc;
        logic        eneg;
        logic [13:0] ev;
    } job_t;

    localparam logic [13:0] COUNT_MAX = 14'h3FFF;
    localparam int          EXP_LIMIT = 511;

    localparam logic [63:0] DBL_INF = 64'h7FF0_0000_0000_0000;
    localparam logic [63:0] DBL_NAN = 64'hFFF8_0000_0000_0000;

    // 10^(2^i) as doubles
    localparam logic [63:0] POW10_TBL [0:8] = '{
        64'h4024_0000_0000_0000,
        64'h4059_0000_0000_0000,
        64'h40C3_8800_0000_0000,
        64'h4197_D784_0000_0000,
        64'h4341_C379_37E0_8000,
        64'h4693_B8B5_B505_6E17,
        64'h4D38_4F03_E93F_F9F5,
        64'h5A82_7748_F930_1D32,
        64'h7515_4FDD_7F73_BF3C
    };

endpackage

### hw/rtl/dtd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtd_front
// Character scanner: one char per cycle unless queue full; emits number jobs.
// ----------------------------------------------------------------------------
module dtd_front #(
    parameter int MAX_KEPT_DIGITS = 18
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  logic [7:0]      s_tdata,   // char_code
    input  logic [0:0]      s_tuser,   // starts_number
    input  logic            s_tlast,   // ends_text
    input  logic            q_full,
    output logic            push,
    output dtd_pkg::job_t   push_job
);

    typedef enum logic [2:0] {
        PH_SPACE, PH_SIGN, PH_MANT, PH_ESIGN, PH_EDIG
    } phase_t;

    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_POINT = 8'h2E;
    localparam logic [7:0] CH_E_LO  = 8'h65;
    localparam logic [7:0] CH_E_UP  = 8'h45;

    logic        open_reg, open_next;
    phase_t      phase_reg, phase_next;
    logic        neg_reg, neg_next;
    logic        point_reg, point_next;
    logic [59:0] mant_reg, mant_next;
    logic [4:0]  kdc_reg, kdc_next;
    logic [13:0] idc_reg, idc_next;
    logic        eneg_reg, eneg_next;
    logic [13:0] ev_reg, ev_next;

    logic        accept, stop, take_m, take_e, is_digit, is_space;
    logic [3:0]  dig;
    logic [17:0] ev_mul;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;
    assign dig      = s_tdata[3:0];
    assign is_digit = s_tdata inside {[8'd48:8'd57]};
    assign is_space = s_tdata inside {8'd32, [8'd9:8'd13]};

    always_comb begin
        open_next  = open_reg;
        phase_next = phase_reg;
        neg_next   = neg_reg;
        point_next = point_reg;
        mant_next  = mant_reg;
        kdc_next   = kdc_reg;
        idc_next   = idc_reg;
        eneg_next  = eneg_reg;
        ev_next    = ev_reg;
        stop       = 1'b0;
        take_m     = 1'b0;
        take_e     = 1'b0;
        ev_mul     = '0;
        if (s_tuser[0]) begin
            open_next  = 1'b1;
            phase_next = PH_SPACE;
            neg_next   = 1'b0;
            point_next = 1'b0;
            mant_next  = '0;
            kdc_next   = '0;
            idc_next   = '0;
            eneg_next  = 1'b0;
            ev_next    = '0;
        end
        case (phase_next)
            PH_SPACE: begin
                if (is_space) begin
                end else if (s_tdata == CH_MINUS) begin
                    neg_next   = 1'b1;
                    phase_next = PH_SIGN;
                end else if (s_tdata == CH_PLUS) begin
                    phase_next = PH_SIGN;
                end else if (is_digit) begin
                    take_m     = 1'b1;
                    phase_next = PH_MANT;
                end else if (s_tdata == CH_POINT) begin
                    point_next = 1'b1;
                    phase_next = PH_MANT;
                end else begin
                    stop = 1'b1;
                end
            end
            PH_SIGN, PH_MANT: begin
                if (is_digit) begin
                    take_m     = 1'b1;
                    phase_next = PH_MANT;
                end else if (s_tdata == CH_POINT && !point_next) begin
                    point_next = 1'b1;
                    phase_next = PH_MANT;
                end else if ((s_tdata == CH_E_LO || s_tdata == CH_E_UP) && kdc_next != '0) begin
                    phase_next = PH_ESIGN;
                end else begin
                    stop = 1'b1;
                end
            end
            PH_ESIGN: begin
                if (s_tdata == CH_MINUS) begin
                    eneg_next  = 1'b1;
                    phase_next = PH_EDIG;
                end else if (s_tdata == CH_PLUS) begin
                    phase_next = PH_EDIG;
                end else if (is_digit) begin
                    take_e     = 1'b1;
                    phase_next = PH_EDIG;
                end else begin
                    stop = 1'b1;
                end
            end
            PH_EDIG: begin
                if (is_digit) begin
                    take_e = 1'b1;
                end else begin
                    stop = 1'b1;
                end
            end
            default: begin
                stop = 1'b1;
            end
        endcase
        if (take_m) begin
            if (kdc_next < 5'(MAX_KEPT_DIGITS)) begin
                mant_next = (mant_next << 3) + (mant_next << 1) + 60'(dig);
                kdc_next  = kdc_next + 5'd1;
            end
            if (!point_next && idc_next != dtd_pkg::COUNT_MAX) begin
                idc_next = idc_next + 14'd1;
            end
        end
        if (take_e) begin
            ev_mul  = 18'({ev_next, 3'b000}) + 18'({ev_next, 1'b0}) + 18'(dig);
            ev_next = (ev_mul > 18'(dtd_pkg::COUNT_MAX)) ? dtd_pkg::COUNT_MAX : ev_mul[13:0];
        end
    end

    assign push          = accept && open_next && (stop || s_tlast);
    assign push_job.neg  = neg_next;
    assign push_job.mant = mant_next;
    assign push_job.idc  = idc_next;
    assign push_job.kdc  = kdc_next;
    assign push_job.eneg = eneg_next;
    assign push_job.ev   = ev_next;

    always_ff @(posedge aclk) begin
        if (!aresetn || (accept && push)) begin
            open_reg  <= 1'b0;
            phase_reg <= PH_SPACE;
            neg_reg   <= 1'b0;
            point_reg <= 1'b0;
            mant_reg  <= '0;
            kdc_reg   <= '0;
            idc_reg   <= '0;
            eneg_reg  <= 1'b0;
            ev_reg    <= '0;
        end else if (accept) begin
            open_reg  <= open_next;
            phase_reg <= phase_next;
            neg_reg   <= neg_next;
            point_reg <= point_next;
            mant_reg  <= mant_next;
            kdc_reg   <= kdc_next;
            idc_reg   <= idc_next;
            eneg_reg  <= eneg_next;
            ev_reg    <= ev_next;
        end
    end

endmodule

### hw/rtl/dtd_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtd_queue
// Small register FIFO of parsed number jobs between scanner and arithmetic.
// ----------------------------------------------------------------------------
module dtd_queue #(
    parameter int DEPTH = 2
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  dtd_pkg::job_t push_job,
    output logic          full,
    input  logic          pop,
    output dtd_pkg::job_t pop_job,
    output logic          job_valid
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    dtd_pkg::job_t mem_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] cnt_reg;

    assign full      = (cnt_reg == CW'(DEPTH));
    assign job_valid = (cnt_reg != '0);
    assign pop_job   = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
            end
            if (push && !pop) begin
                cnt_reg <= cnt_reg + CW'(1);
            end else if (pop && !push) begin
                cnt_reg <= cnt_reg - CW'(1);
            end
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |-> (cnt_reg != CW'(DEPTH)))
        else $error("job queue overflow");
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> (cnt_reg != '0))
        else $error("job queue underflow");
    a_count_up: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |=> (cnt_reg == $past(cnt_reg) + CW'(1)))
        else $error("job queue count mismatch");
`endif

endmodule

### hw/rtl/dtd_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtd_back
// Arithmetic sequencer: integer to double, power-of-ten scale, multiply or
// divide with round to nearest even, and the output register.
// ----------------------------------------------------------------------------
module dtd_back (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          job_valid,
    input  dtd_pkg::job_t job,
    output logic          job_pop,
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [63:0]   m_tdata,   // value_bits
    output logic [1:0]    m_tuser    // out_of_range, no_digits
);

    typedef enum logic [3:0] {
        ST_IDLE, ST_EXP, ST_NORM, ST_SCALE, ST_FINAL,
        ST_MUL, ST_MRND, ST_DIV, ST_DRND, ST_OUT
    } state_t;

    state_t             state_reg;
    dtd_pkg::job_t      job_reg;
    logic [59:0]        mant_reg;
    logic signed [13:0] ne_reg;
    logic               none_reg, range_reg, div_reg;
    logic [8:0]         mag_reg;
    logic               v_zero_reg;
    logic [52:0]        v_sig_reg;
    logic [10:0]        v_e_reg;
    logic               s_have_reg, s_inf_reg;
    logic [52:0]        s_sig_reg;
    logic [10:0]        s_e_reg;
    logic [3:0]         idx_reg;
    logic               fin_reg;
    logic [52:0]        ma_sig_reg, mb_sig_reg;
    logic [10:0]        ma_e_reg, mb_e_reg;
    logic [2:0]         mstep_reg;
    logic [53:0]        prod_reg;
    logic [105:0]       acc_reg;
    logic [53:0]        rem_reg;
    logic [54:0]        q_reg;
    logic [5:0]         dcnt_reg;
    logic signed [13:0] de_reg;
    logic [63:0]        res_reg;
    logic [63:0]        out_bits_reg;
    logic [1:0]         out_user_reg;
    logic               m_valid_reg;
    logic               out_load;

    function automatic logic [63:0] fp_round(input logic signed [13:0] e,
                                             input logic [54:0] sig,
                                             input logic st);
        logic [54:0]        s;
        logic [54:0]        mask;
        logic               stk;
        logic [5:0]         sh;
        logic signed [13:0] shf;
        logic [10:0]        ef;
        logic               inc;
        logic [63:0]        base;
        if (e >= 14'sd2047) begin
            return dtd_pkg::DBL_INF;
        end
        if (e <= 14'sd0) begin
            shf  = 14'sd1 - e;
            sh   = (shf > 14'sd55) ? 6'd55 : shf[5:0];
            mask = (55'd1 << sh) - 55'd1;
            s    = sig >> sh;
            stk  = st | (|(sig & mask));
            ef   = '0;
        end else begin
            s  = sig;
            stk = st;
            ef = e[10:0] - 11'd1;
        end
        inc  = s[1] & (s[0] | stk | s[2]);
        base = {1'b0, ef, 52'b0} + {11'b0, s[54:2]};
        return base + 64'(inc);
    endfunction

    // decimal exponent
    logic signed [16:0] e_base, e_dec, mag_full;
    logic               over;
    always_comb begin
        e_base   = $signed({3'b000, job_reg.idc}) - $signed({12'b0, job_reg.kdc});
        e_dec    = job_reg.eneg ? e_base - $signed({3'b000, job_reg.ev})
                                : e_base + $signed({3'b000, job_reg.ev});
        mag_full = e_dec[16] ? -e_dec : e_dec;
        over     = mag_full > 17'sd511;
    end

    // shared 27x27 partial product multiplier
    logic [26:0]  mul_a, mul_b;
    logic [53:0]  mul_p;
    logic [105:0] acc_add;
    always_comb begin
        case (mstep_reg[1:0])
            2'd0: begin
                mul_a = ma_sig_reg[26:0];
                mul_b = mb_sig_reg[26:0];
            end
            2'd1: begin
                mul_a = ma_sig_reg[26:0];
                mul_b = {1'b0, mb_sig_reg[52:27]};
            end
            2'd2: begin
                mul_a = {1'b0, ma_sig_reg[52:27]};
                mul_b = mb_sig_reg[26:0];
            end
            default: begin
                mul_a = {1'b0, ma_sig_reg[52:27]};
                mul_b = {1'b0, mb_sig_reg[52:27]};
            end
        endcase
        mul_p = mul_a * mul_b;
        case (mstep_reg)
            3'd1:       acc_add = 106'(prod_reg);
            3'd2, 3'd3: acc_add = 106'(prod_reg) << 27;
            default:    acc_add = 106'(prod_reg) << 54;
        endcase
    end

    // divider step
    logic        div_ge;
    logic [53:0] div_sel;
    always_comb begin
        div_ge  = rem_reg >= {1'b0, s_sig_reg};
        div_sel = div_ge ? rem_reg - {1'b0, s_sig_reg} : rem_reg;
    end

    // shared rounding
    logic signed [13:0] rnd_e;
    logic [54:0]        rnd_sig;
    logic               rnd_st, mhi;
    logic [63:0]        rnd_bits;
    always_comb begin
        mhi = acc_reg[105];
        case (state_reg)
            ST_NORM: begin
                rnd_e   = ne_reg;
                rnd_sig = mant_reg[59:5];
                rnd_st  = |mant_reg[4:0];
            end
            ST_MRND: begin
                rnd_e   = $signed({3'b000, ma_e_reg}) + $signed({3'b000, mb_e_reg})
                          - 14'sd1023 + $signed({13'b0, mhi});
                rnd_sig = mhi ? acc_reg[105:51] : acc_reg[104:50];
                rnd_st  = mhi ? |acc_reg[50:0] : |acc_reg[49:0];
            end
            default: begin
                rnd_e   = de_reg;
                rnd_sig = q_reg;
                rnd_st  = rem_reg != '0;
            end
        endcase
        rnd_bits = fp_round(rnd_e, rnd_sig, rnd_st);
    end

    assign job_pop  = (state_reg == ST_IDLE) && job_valid;
    assign out_load = (state_reg == ST_OUT) && (!m_valid_reg || m_tready);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = out_bits_reg;
    assign m_tuser  = out_user_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_valid_reg  <= 1'b0;
            s_have_reg   <= 1'b0;
            s_inf_reg    <= 1'b0;
            idx_reg      <= '0;
            mstep_reg    <= '0;
            dcnt_reg     <= '0;
            fin_reg      <= 1'b0;
            out_user_reg <= '0;
        end else begin
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (job_valid) begin
                        job_reg   <= job;
                        state_reg <= ST_EXP;
                    end
                end
                ST_EXP: begin
                    none_reg   <= (job_reg.kdc == '0);
                    range_reg  <= (job_reg.kdc != '0) && over;
                    mag_reg    <= over ? 9'(dtd_pkg::EXP_LIMIT) : mag_full[8:0];
                    div_reg    <= e_dec[16];
                    mant_reg   <= job_reg.mant;
                    ne_reg     <= 14'sd1082;
                    v_zero_reg <= (job_reg.mant == '0);
                    s_have_reg <= 1'b0;
                    s_inf_reg  <= 1'b0;
                    idx_reg    <= '0;
                    if (job_reg.kdc == '0) begin
                        res_reg   <= '0;
                        state_reg <= ST_OUT;
                    end else if (job_reg.mant == '0) begin
                        state_reg <= ST_SCALE;
                    end else begin
                        state_reg <= ST_NORM;
                    end
                end
                ST_NORM: begin
                    if (mant_reg[59]) begin
                        v_e_reg   <= rnd_bits[62:52];
                        v_sig_reg <= {1'b1, rnd_bits[51:0]};
                        state_reg <= ST_SCALE;
                    end else begin
                        mant_reg <= mant_reg << 1;
                        ne_reg   <= ne_reg - 14'sd1;
                    end
                end
                ST_SCALE: begin
                    if (idx_reg == 4'd9) begin
                        state_reg <= ST_FINAL;
                    end else begin
                        idx_reg <= idx_reg + 4'd1;
                        if (mag_reg[idx_reg]) begin
                            if (!s_have_reg) begin
                                s_have_reg <= 1'b1;
                                s_e_reg    <= dtd_pkg::POW10_TBL[idx_reg][62:52];
                                s_sig_reg  <= {1'b1, dtd_pkg::POW10_TBL[idx_reg][51:0]};
                            end else if (!s_inf_reg) begin
                                ma_sig_reg <= s_sig_reg;
                                ma_e_reg   <= s_e_reg;
                                mb_sig_reg <= {1'b1, dtd_pkg::POW10_TBL[idx_reg][51:0]};
                                mb_e_reg   <= dtd_pkg::POW10_TBL[idx_reg][62:52];
                                fin_reg    <= 1'b0;
                                mstep_reg  <= '0;
                                acc_reg    <= '0;
                                state_reg  <= ST_MUL;
                            end
                        end
                    end
                end
                ST_FINAL: begin
                    if (mag_reg == '0) begin
                        res_reg   <= v_zero_reg ? '0 : {1'b0, v_e_reg, v_sig_reg[51:0]};
                        state_reg <= ST_OUT;
                    end else if (div_reg) begin
                        if (v_zero_reg || s_inf_reg) begin
                            res_reg   <= '0;
                            state_reg <= ST_OUT;
                        end else begin
                            if (v_sig_reg < s_sig_reg) begin
                                rem_reg <= {v_sig_reg, 1'b0};
                                de_reg  <= $signed({3'b000, v_e_reg})
                                           - $signed({3'b000, s_e_reg}) + 14'sd1022;
                            end else begin
                                rem_reg <= {1'b0, v_sig_reg};
                                de_reg  <= $signed({3'b000, v_e_reg})
                                           - $signed({3'b000, s_e_reg}) + 14'sd1023;
                            end
                            q_reg     <= '0;
                            dcnt_reg  <= '0;
                            state_reg <= ST_DIV;
                        end
                    end else if (s_inf_reg) begin
                        res_reg   <= v_zero_reg ? dtd_pkg::DBL_NAN : dtd_pkg::DBL_INF;
                        state_reg <= ST_OUT;
                    end else if (v_zero_reg) begin
                        res_reg   <= '0;
                        state_reg <= ST_OUT;
                    end else begin
                        ma_sig_reg <= v_sig_reg;
                        ma_e_reg   <= v_e_reg;
                        mb_sig_reg <= s_sig_reg;
                        mb_e_reg   <= s_e_reg;
                        fin_reg    <= 1'b1;
                        mstep_reg  <= '0;
                        acc_reg    <= '0;
                        state_reg  <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    if (mstep_reg < 3'd4) begin
                        prod_reg <= mul_p;
                    end
                    if (mstep_reg != 3'd0) begin
                        acc_reg <= acc_reg + acc_add;
                    end
                    if (mstep_reg == 3'd4) begin
                        state_reg <= ST_MRND;
                    end else begin
                        mstep_reg <= mstep_reg + 3'd1;
                    end
                end
                ST_MRND: begin
                    if (fin_reg) begin
                        res_reg   <= rnd_bits;
                        state_reg <= ST_OUT;
                    end else begin
                        if (rnd_bits[62:52] == 11'h7FF) begin
                            s_inf_reg <= 1'b1;
                        end else begin
                            s_e_reg   <= rnd_bits[62:52];
                            s_sig_reg <= {1'b1, rnd_bits[51:0]};
                        end
                        state_reg <= ST_SCALE;
                    end
                end
                ST_DIV: begin
                    rem_reg  <= {div_sel[52:0], 1'b0};
                    q_reg    <= {q_reg[53:0], div_ge};
                    dcnt_reg <= dcnt_reg + 6'd1;
                    if (dcnt_reg == 6'd54) begin
                        state_reg <= ST_DRND;
                    end
                end
                ST_DRND: begin
                    res_reg   <= rnd_bits;
                    state_reg <= ST_OUT;
                end
                ST_OUT: begin
                    if (out_load) begin
                        out_bits_reg <= res_reg ^ {job_reg.neg, 63'b0};
                        out_user_reg <= {none_reg, range_reg};
                        state_reg    <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

### hw/rtl/decimal_text_to_double.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// decimal_text_to_double
// Streaming decimal text to IEEE 754 double converter.
//
// Channel  Dir  Transfer      Payload (lowest bit first)
// s_       in   character     tdata: char_code; tuser: starts_number;
//                             tlast: ends_text
// m_       out  number        tdata: value_bits; tuser: out_of_range, no_digits
//
// The scanner takes one character per cycle and stalls only when the job
// queue is full. The arithmetic unit takes a number only when idle and
// works through it by one-bit normalization, double multiplies on the
// shared 27x27 multiplier, and the one-bit-per-cycle divider. Reset is
// synchronous and clears all control.
// ----------------------------------------------------------------------------
module decimal_text_to_double #(
    parameter int MAX_KEPT_DIGITS = 18,
    parameter int QUEUE_DEPTH     = 2
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // char_code
    input  logic [0:0]  s_tuser,    // starts_number
    input  logic        s_tlast,    // ends_text
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,    // value_bits
    output logic [1:0]  m_tuser     // out_of_range, no_digits
);

    dtd_pkg::job_t push_job, pop_job;
    logic          push, q_full, pop, job_valid;

    dtd_front #(
        .MAX_KEPT_DIGITS (MAX_KEPT_DIGITS)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .q_full   (q_full),
        .push     (push),
        .push_job (push_job)
    );

    dtd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_job  (push_job),
        .full      (q_full),
        .pop       (pop),
        .pop_job   (pop_job),
        .job_valid (job_valid)
    );

    dtd_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .job_valid (job_valid),
        .job       (pop_job),
        .job_pop   (pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule
